// ===== hdl/assert_macros.svh =====
// Assertion macros, included by url_percent_decoder.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== hdl/upd_pkg.sv =====
// Types, constants and helper functions for the URL percent decoder.
`default_nettype none

package upd_pkg;

  localparam logic [7:0] PCT_CHAR = 8'h25;

  // Escape phase codes
  localparam logic [1:0] PH_IDLE = 2'd0;  // not inside an escape
  localparam logic [1:0] PH_PCT  = 2'd1;  // '%' seen
  localparam logic [1:0] PH_HELD = 2'd2;  // '%' and first follower seen

  localparam int MAX_RES = 3;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } out_t;

  // Everything one input byte produces.
  typedef struct packed {
    logic [1:0]                 cnt;
    logic [MAX_RES-1:0][7:0]    res_byte;
    logic [MAX_RES-1:0]         res_last;
    logic [1:0]                 nxt_phase;
    logic [7:0]                 nxt_held;
  } step_t;

  function automatic logic is_alnum(input logic [7:0] c);
    return (c inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]});
  endfunction

  function automatic logic [3:0] nibble_of(input logic [7:0] c);
    logic [7:0] v;
    v = 8'h00;
    if (c inside {[8'h30:8'h39]}) v = c - 8'h30;
    else if (c inside {[8'h41:8'h46]}) v = c - 8'h37;
    else if (c inside {[8'h61:8'h66]}) v = c - 8'h57;
    return v[3:0];
  endfunction

endpackage

`default_nettype wire

// ===== hdl/upd_step.sv =====
// Combinational decode of one input byte against the escape state.
`default_nettype none

module upd_step
  import upd_pkg::*;
(
  input  wire logic [1:0] phase,
  input  wire logic [7:0] held,
  input  wire in_t        in_item,
  output step_t           st
);

  logic [7:0] b;
  logic       lst;

  assign b   = in_item.in_byte;
  assign lst = in_item.in_last;

  always_comb begin
    st           = '0;
    st.nxt_phase = PH_IDLE;
    st.nxt_held  = held;
    case (phase)
      PH_PCT: begin
        if (lst) begin
          // escape cut short: '%' then the follower as is
          st.cnt         = 2'd2;
          st.res_byte[0] = PCT_CHAR;
          st.res_byte[1] = b;
          st.res_last[1] = 1'b1;
        end else begin
          st.nxt_held  = b;
          st.nxt_phase = PH_HELD;
        end
      end
      PH_HELD: begin
        if (is_alnum(held) && is_alnum(b)) begin
          st.cnt         = 2'd1;
          st.res_byte[0] = {nibble_of(held), nibble_of(b)};
          st.res_last[0] = lst;
        end else begin
          st.res_byte[0] = PCT_CHAR;
          if (held != PCT_CHAR) begin
            // held byte passes, new byte starts from idle
            st.res_byte[1] = held;
            if (b != PCT_CHAR) begin
              st.cnt         = 2'd3;
              st.res_byte[2] = b;
              st.res_last[2] = lst;
            end else if (lst) begin
              st.cnt         = 2'd3;
              st.res_byte[2] = PCT_CHAR;
              st.res_last[2] = 1'b1;
            end else begin
              st.cnt       = 2'd2;
              st.nxt_phase = PH_PCT;
            end
          end else begin
            // held '%' opens a new escape with the new byte as follower
            if (lst) begin
              st.cnt         = 2'd3;
              st.res_byte[1] = PCT_CHAR;
              st.res_byte[2] = b;
              st.res_last[2] = 1'b1;
            end else begin
              st.cnt       = 2'd1;
              st.nxt_held  = b;
              st.nxt_phase = PH_HELD;
            end
          end
        end
      end
      default: begin
        if (b != PCT_CHAR) begin
          st.cnt         = 2'd1;
          st.res_byte[0] = b;
          st.res_last[0] = lst;
        end else if (lst) begin
          st.cnt         = 2'd1;
          st.res_byte[0] = PCT_CHAR;
          st.res_last[0] = 1'b1;
        end else begin
          st.nxt_phase = PH_PCT;
        end
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/url_percent_decoder.sv =====
// URL percent decoder: one byte in per cycle, up to three decoded bytes out.
// A result is on out_data in the cycle after the input transfer that makes it.
// Throughput: one input byte per cycle while each byte gives at most one result and out_ready is high;
// a byte with N results holds in_ready low until N-1 of them have left.
// Reset (rst_n low, synchronous): escape state idle, result buffer empty.
`default_nettype none

`include "assert_macros.svh"

module url_percent_decoder
  import upd_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire in_t  in_data,
  output logic      out_valid,
  input  wire logic out_ready,
  output out_t      out_data
);

  logic [1:0]              phase_r, phase_nxt;
  logic [7:0]              held_r, held_nxt;
  logic [1:0]              cnt_r, cnt_nxt;
  logic [MAX_RES-1:0][7:0] res_byte_r, res_byte_nxt;
  logic [MAX_RES-1:0]      res_last_r, res_last_nxt;
  step_t                   st;
  logic                    in_xfer, out_xfer;

  upd_step u_step (
    .phase   (phase_r),
    .held    (held_r),
    .in_item (in_data),
    .st      (st)
  );

  assign out_valid         = (cnt_r != 2'd0);
  assign out_data.out_byte = res_byte_r[0];
  assign out_data.out_last = res_last_r[0];

  // Take a new byte once the buffer drains this cycle.
  assign in_ready = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_ready);
  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;

  always_comb begin
    phase_nxt    = phase_r;
    held_nxt     = held_r;
    cnt_nxt      = cnt_r;
    res_byte_nxt = res_byte_r;
    res_last_nxt = res_last_r;
    if (in_xfer) begin
      phase_nxt    = st.nxt_phase;
      held_nxt     = st.nxt_held;
      cnt_nxt      = st.cnt;
      res_byte_nxt = st.res_byte;
      res_last_nxt = st.res_last;
    end else if (out_xfer) begin
      cnt_nxt      = cnt_r - 2'd1;
      res_byte_nxt = {8'h00, res_byte_r[MAX_RES-1:1]};
      res_last_nxt = {1'b0, res_last_r[MAX_RES-1:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      held_r  <= 8'h00;
      cnt_r   <= 2'd0;
    end else begin
      phase_r <= phase_nxt;
      held_r  <= held_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_byte_r <= res_byte_nxt;
    res_last_r <= res_last_nxt;
  end

  `ASSERT_IMPLIES(a_no_accept_when_full, clk, rst_n, cnt_r > 2'd1, !in_ready)
  `ASSERT_NEXT(a_last_closes_escape, clk, rst_n, in_xfer && in_data.in_last,
               phase_r == PH_IDLE)
  `ASSERT_NEXT(a_silent_byte_in_escape, clk, rst_n, in_xfer && (st.cnt == 2'd0),
               phase_r != PH_IDLE)

endmodule

`default_nettype wire
